[design/bitmap_block_allocator_assert.svh]
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent holds in this cycle, consequent in the same cycle
`define BBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

    // map geometry
    localparam int unsigned NUM_BLOCKS    = 8192;
    localparam int unsigned TAIL_RESERVED = 3;
    localparam int unsigned WORD_BITS     = 32;

    localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WADDR_W   = $clog2(MAP_WORDS);
    localparam int unsigned OFF_W     = $clog2(WORD_BITS);
    localparam int unsigned BLK_W     = 13;
    localparam int unsigned OP_W      = 2;

    // allocate scans blocks 1 .. ALLOC_END-1
    localparam int unsigned ALLOC_END =
        (NUM_BLOCKS > TAIL_RESERVED) ? (NUM_BLOCKS - TAIL_RESERVED) : 0;
    localparam int unsigned LAST_SCAN_WORD =
        (ALLOC_END > 1) ? ((ALLOC_END - 1) / WORD_BITS) : 0;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WADDR_W-1:0]   t_waddr;
    typedef logic [OFF_W-1:0]     t_off;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_ALLOC = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [BLK_W-1:0] block_index;
    } t_in_word;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [BLK_W-1:0] allocated_block;
        logic             index_error;
    } t_out_word;

    // lowest candidate bit of one map word
    typedef struct packed {
        logic hit;
        t_off pos;
    } t_find;

    // map word after reset: block 0 and the tail blocks are used
    function automatic t_word reset_word(input t_waddr addr);
        t_word       w;
        int unsigned blk;
        w = '0;
        for (int unsigned o = 0; o < WORD_BITS; o++) begin
            blk  = int'(addr) * WORD_BITS + o;
            w[o] = (blk == 0) ||
                   ((blk + TAIL_RESERVED >= NUM_BLOCKS) && (blk < NUM_BLOCKS));
        end
        return w;
    endfunction

    // bits of a word that allocate may grant
    function automatic t_word scan_mask(input t_waddr addr);
        t_word       w;
        int unsigned blk;
        w = '0;
        for (int unsigned o = 0; o < WORD_BITS; o++) begin
            blk  = int'(addr) * WORD_BITS + o;
            w[o] = (blk >= 1) && (blk < ALLOC_END);
        end
        return w;
    endfunction

endpackage

[design/bba_first_free.sv]
`timescale 1ns / 1ps

module bba_first_free (
    input  bba_pkg::t_word i_cand,
    output bba_pkg::t_find o_find
);
    import bba_pkg::*;

    // priority encoder, lowest set bit wins
    always_comb begin
        o_find = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_cand[i]) begin
                o_find.hit = 1'b1;
                o_find.pos = t_off'(i);
            end
        end
    end

endmodule

[design/bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// Bitmap free-block allocator, first fit, one used bit per block.
// Input channel i_valid/o_ready carries i_word (opcode, block_index); output
// channel o_valid/i_ready carries o_word, one result word per input word.
// The map lives in a 256 x 32 synchronous RAM (one read, one write port).
// Read, mark used and mark free: the word is read; mark used and mark
// free modify it and write it back. The result goes into the output
// register as the state returns to idle; o_ready is low until then.
// Allocate reads one map word per cycle from word 0 upward through the
// priority encoder and stops at the first word with a free block or after
// the last map word; no new input word is taken until the scan is done.
// After reset a clearing pass writes the reset contents into all 256 map
// words with o_ready low; then block 0 and the last three blocks are used
// and all others free.
// A result waits in the output register while i_ready is low; the next
// input word is still accepted, and its write-back and result are held
// until the output register frees up.
module bitmap_block_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bba_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output bba_pkg::t_out_word o_word
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RMW   = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    t_waddr    r_clr_addr, n_clr_addr;
    t_waddr    r_scan_addr, n_scan_addr;
    logic [OP_W-1:0]  r_op, n_op;
    logic [BLK_W-1:0] r_idx, n_idx;
    logic      r_err, n_err;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out, n_out;

    // map ram
    t_word     r_map [MAP_WORDS];
    t_word     r_rd_data;
    logic      rd_en;
    t_waddr    rd_addr;
    logic      wr_en;
    t_waddr    wr_addr;
    t_word     wr_data;

    t_word     cand;
    t_find     find;
    logic      out_free;
    logic      last_word;
    t_off      off;

    // first free block in the word under scan
    assign cand = ~r_rd_data & scan_mask(r_scan_addr);

    bba_first_free u_first_free (
        .i_cand (cand),
        .o_find (find)
    );

    assign out_free  = !r_out_valid || i_ready;
    assign last_word = (r_scan_addr == t_waddr'(LAST_SCAN_WORD));
    assign off       = r_idx[OFF_W-1:0];

    // control and read-modify-write
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_scan_addr = r_scan_addr;
        n_op        = r_op;
        n_idx       = r_idx;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        o_ready     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = reset_word(r_clr_addr);
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == t_waddr'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op  = i_word.opcode;
                    n_idx = i_word.block_index;
                    n_err = (32'(i_word.block_index) >= NUM_BLOCKS);
                    rd_en = 1'b1;
                    if (i_word.opcode == OP_ALLOC) begin
                        rd_addr     = '0;
                        n_scan_addr = '0;
                        n_state     = S_SCAN;
                    end else begin
                        rd_addr = t_waddr'(i_word.block_index >> OFF_W);
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out                 = '0;
                    n_out.index_error     = r_err;
                    n_out.bit_value       = !r_err && (r_op == OP_READ) && r_rd_data[off];
                    wr_addr               = t_waddr'(r_idx >> OFF_W);
                    wr_data               = r_rd_data;
                    wr_data[off]          = (r_op == OP_SET);
                    wr_en                 = !r_err && ((r_op == OP_SET) || (r_op == OP_CLEAR));
                    n_state               = S_IDLE;
                end
            end
            S_SCAN: begin
                if (find.hit || last_word) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        if (find.hit) begin
                            n_out.found           = 1'b1;
                            n_out.allocated_block = BLK_W'({r_scan_addr, find.pos});
                            wr_en                 = 1'b1;
                            wr_addr               = r_scan_addr;
                            wr_data               = r_rd_data;
                            wr_data[find.pos]     = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    rd_en       = 1'b1;
                    rd_addr     = r_scan_addr + 1'b1;
                    n_scan_addr = r_scan_addr + 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // map ram ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_map[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_err       <= n_err;
        r_out       <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    `include "bitmap_block_allocator_assert.svh"

    `BBA_ASSERT_IMPLY(a_grant_range, i_clk, i_rst_n, r_out_valid && r_out.found, (32'(r_out.allocated_block) >= 1) && (32'(r_out.allocated_block) < ALLOC_END), "granted block outside the allocatable range")
    `BBA_ASSERT_IMPLY(a_grant_clean, i_clk, i_rst_n, r_out_valid && r_out.found, !r_out.bit_value && !r_out.index_error, "allocate word carries read or error flags")
    `BBA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second word accepted while one is in flight")
    `BBA_ASSERT_IMPLY(a_scan_write, i_clk, i_rst_n, (r_state == S_SCAN) && wr_en, find.hit && out_free, "scan wrote the map without a free block")

endmodule
